// ===== rtl/bcat_pkg.sv =====
// Shared types and constants for the block chain allocation table.
package bcat_pkg;

  localparam int TABLE_ENTRIES    = 4096;
  localparam int FIRST_DATA_BLOCK = 5;
  localparam int ADDR_W           = $clog2(TABLE_ENTRIES);
  localparam int CNT_W            = ADDR_W + 1;
  localparam int CUR_W            = 13;
  localparam int ENTRY_W          = 14;

  localparam logic [ENTRY_W-1:0] END_MARK  = '1;
  localparam logic [ENTRY_W-1:0] FREE_MARK = '0;

  typedef enum logic [1:0] {
    CMD_ALLOC_FIRST = 2'd0,
    CMD_ALLOC_AFTER = 2'd1,
    CMD_NEXT_LINK   = 2'd2,
    CMD_RELEASE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic                valid;
    logic [ENTRY_W-1:0]  block;
    status_t             status;
  } result_t;

endpackage

// ===== rtl/block_chain_allocation_table.sv =====
// Block chain allocation table top level: stream ports and output register.
//
// One request on the in_ channel gives one result on the out_ channel.
// in_tuser carries the command (allocate first, allocate after, next link,
// release); in_tdata carries the current block number. out_tdata carries
// the result block (all ones in [13:0] for none or end of chain),
// out_tuser the status (ok, no free block, block out of range).
// Next link and release read the addressed entry and answer with its link.
// Allocation scans the table from entry 0 through one read port,
// one entry per cycle, stopping at the first free entry, or at the
// last entry when the table is full; allocate after then writes the
// link in a further state before it answers.
// A request is taken only while the sequencer is idle, one at a time.
// After reset a clearing pass writes every entry to free, one per cycle,
// TABLE_ENTRIES (4096) entries in all, during which in_tready stays low.
// A stalled receiver holds the result in the output register; the next
// request is still taken and its result waits in the sequencer.
module block_chain_allocation_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [12:0] cur_block
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [13:0] result_block
  output logic [1:0]  out_tuser   // [1:0] status
);

  bcat_pkg::result_t                res;
  logic                             res_ready;
  bcat_pkg::mem_req_t               mem_req;
  logic [bcat_pkg::ENTRY_W-1:0]     rd_data;

  logic                             out_v_r, out_v_nxt;
  logic [bcat_pkg::ENTRY_W-1:0]     out_blk_r;
  bcat_pkg::status_t                out_st_r;

  bcat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_cmd    (bcat_pkg::cmd_t'(in_tuser)),
    .in_cur    (in_tdata[bcat_pkg::CUR_W-1:0]),
    .in_ready  (in_tready),
    .res       (res),
    .res_ready (res_ready),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  bcat_table u_table (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign res_ready = !out_v_r || out_tready;

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (res.valid && res_ready) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_blk_r <= res.block;
      out_st_r  <= res.status;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(16 - bcat_pkg::ENTRY_W){1'b0}}, out_blk_r};
  assign out_tuser  = out_st_r;

endmodule

// ===== rtl/bcat_table.sv =====
// Link table storage: one write port, one read port with registered data.
module bcat_table (
  input  logic                            clk,
  input  bcat_pkg::mem_req_t              req,
  output logic [bcat_pkg::ENTRY_W-1:0]    rd_data
);

  logic [bcat_pkg::ENTRY_W-1:0] mem [bcat_pkg::TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/bcat_ctrl.sv =====
// Command sequencer: clearing pass, free-entry scan, link read and update.
module bcat_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  bcat_pkg::cmd_t                 in_cmd,
  input  logic [bcat_pkg::CUR_W-1:0]     in_cur,
  output logic                           in_ready,
  output bcat_pkg::result_t              res,
  input  logic                           res_ready,
  output bcat_pkg::mem_req_t             mem_req,
  input  logic [bcat_pkg::ENTRY_W-1:0]   rd_data
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_LINK  = 6'b001000,
    S_READ  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  localparam logic [bcat_pkg::ADDR_W-1:0] LAST_ADDR =
    bcat_pkg::ADDR_W'(bcat_pkg::TABLE_ENTRIES - 1);
  localparam logic [bcat_pkg::CNT_W-1:0] ENTRY_CNT =
    bcat_pkg::CNT_W'(bcat_pkg::TABLE_ENTRIES);

  state_t                          state_r, state_nxt;
  logic [bcat_pkg::ADDR_W-1:0]     clr_r, clr_nxt;
  logic [bcat_pkg::CNT_W-1:0]      iss_r, iss_nxt;
  logic                            chk_v_r, chk_v_nxt;
  logic [bcat_pkg::ADDR_W-1:0]     chk_addr_r, chk_addr_nxt;
  bcat_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [bcat_pkg::ADDR_W-1:0]     cur_idx_r, cur_idx_nxt;
  logic [bcat_pkg::ENTRY_W-1:0]    res_r, res_nxt;
  bcat_pkg::status_t               st_r, st_nxt;

  logic                            in_range;
  logic [bcat_pkg::ADDR_W-1:0]     in_idx;

  assign in_range = (int'(in_cur) >= bcat_pkg::FIRST_DATA_BLOCK) &&
                    (int'(in_cur) < bcat_pkg::FIRST_DATA_BLOCK + bcat_pkg::TABLE_ENTRIES);
  assign in_idx   = bcat_pkg::ADDR_W'(int'(in_cur) - bcat_pkg::FIRST_DATA_BLOCK);

  assign in_ready   = (state_r == S_IDLE);
  assign res.valid  = (state_r == S_RESP);
  assign res.block  = res_r;
  assign res.status = st_r;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    iss_nxt      = iss_r;
    chk_v_nxt    = chk_v_r;
    chk_addr_nxt = chk_addr_r;
    cmd_nxt      = cmd_r;
    cur_idx_nxt  = cur_idx_r;
    res_nxt      = res_r;
    st_nxt       = st_r;
    mem_req      = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = bcat_pkg::FREE_MARK;
        clr_nxt       = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_cmd;
          cur_idx_nxt = in_idx;
          res_nxt     = bcat_pkg::END_MARK;
          st_nxt      = bcat_pkg::ST_RANGE;
          iss_nxt     = '0;
          chk_v_nxt   = 1'b0;
          unique case (in_cmd) inside
            bcat_pkg::CMD_ALLOC_FIRST: begin
              state_nxt = S_SCAN;
            end
            bcat_pkg::CMD_ALLOC_AFTER: begin
              state_nxt = in_range ? S_SCAN : S_RESP;
            end
            bcat_pkg::CMD_NEXT_LINK, bcat_pkg::CMD_RELEASE: begin
              if (in_range) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = in_idx;
                state_nxt     = S_READ;
              end else begin
                state_nxt = S_RESP;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (iss_r < ENTRY_CNT) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = iss_r[bcat_pkg::ADDR_W-1:0];
          iss_nxt       = iss_r + 1'b1;
          chk_v_nxt     = 1'b1;
          chk_addr_nxt  = iss_r[bcat_pkg::ADDR_W-1:0];
        end else begin
          chk_v_nxt = 1'b0;
        end
        if (chk_v_r && rd_data == bcat_pkg::FREE_MARK) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = chk_addr_r;
          mem_req.wdata = bcat_pkg::END_MARK;
          res_nxt       = bcat_pkg::ENTRY_W'(int'(chk_addr_r) + bcat_pkg::FIRST_DATA_BLOCK);
          st_nxt        = bcat_pkg::ST_OK;
          state_nxt     = (cmd_r == bcat_pkg::CMD_ALLOC_AFTER) ? S_LINK : S_RESP;
        end else if (chk_v_r && chk_addr_r == LAST_ADDR) begin
          res_nxt   = bcat_pkg::END_MARK;
          st_nxt    = bcat_pkg::ST_FULL;
          state_nxt = S_RESP;
        end
      end
      S_LINK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cur_idx_r;
        mem_req.wdata = res_r;
        state_nxt     = S_RESP;
      end
      S_READ: begin
        res_nxt = rd_data;
        st_nxt  = bcat_pkg::ST_OK;
        if (cmd_r == bcat_pkg::CMD_RELEASE) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cur_idx_r;
          mem_req.wdata = bcat_pkg::FREE_MARK;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      iss_r   <= '0;
      chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      iss_r   <= iss_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= chk_addr_nxt;
    cmd_r      <= cmd_nxt;
    cur_idx_r  <= cur_idx_nxt;
    res_r      <= res_nxt;
    st_r       <= st_nxt;
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench for the block chain allocation table: predicted link table, scoreboard, stream drivers.
module tb_top;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LAST_BLOCK     = bcat_pkg::FIRST_DATA_BLOCK + bcat_pkg::TABLE_ENTRIES - 1;

  class alloc_table_scoreboard;
    typedef struct {
      logic [bcat_pkg::ENTRY_W-1:0] blk;
      bcat_pkg::status_t            status;
    } reply_t;

    logic [bcat_pkg::ENTRY_W-1:0] links [bcat_pkg::TABLE_ENTRIES];
    int                           errors;
    int                           replies_seen;
    reply_t                       pending_replies [$];

    function new();
      foreach (links[k]) links[k] = bcat_pkg::FREE_MARK;
      errors = 0;
      replies_seen = 0;
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function int lowest_free();
      for (int k = 0; k < bcat_pkg::TABLE_ENTRIES; k++)
        if (links[k] == bcat_pkg::FREE_MARK) return k;
      return -1;
    endfunction

    // Predict the reply to one accepted request and update the table copy.
    function void note_request(bcat_pkg::cmd_t cmd, logic [bcat_pkg::CUR_W-1:0] cur);
      reply_t                       r;
      int                           k;
      int                           ci;
      bit                           in_range;
      logic [bcat_pkg::ENTRY_W-1:0] blk;
      r.blk = bcat_pkg::END_MARK;
      r.status = bcat_pkg::ST_OK;
      in_range = (int'(cur) >= bcat_pkg::FIRST_DATA_BLOCK) && (int'(cur) <= LAST_BLOCK);
      ci = int'(cur) - bcat_pkg::FIRST_DATA_BLOCK;
      if (cmd == bcat_pkg::CMD_ALLOC_FIRST || cmd == bcat_pkg::CMD_ALLOC_AFTER) begin
        if (cmd == bcat_pkg::CMD_ALLOC_AFTER && !in_range) begin
          r.status = bcat_pkg::ST_RANGE;
        end else begin
          k = lowest_free();
          if (k < 0) begin
            r.status = bcat_pkg::ST_FULL;
          end else begin
            blk = bcat_pkg::ENTRY_W'(k + bcat_pkg::FIRST_DATA_BLOCK);
            links[k] = bcat_pkg::END_MARK;
            if (cmd == bcat_pkg::CMD_ALLOC_AFTER) links[ci] = blk;
            r.blk = blk;
          end
        end
      end else begin
        if (!in_range) begin
          r.status = bcat_pkg::ST_RANGE;
        end else begin
          r.blk = links[ci];
          if (cmd == bcat_pkg::CMD_RELEASE) links[ci] = bcat_pkg::FREE_MARK;
        end
      end
      pending_replies.push_back(r);
    endfunction

    task check_result(logic [bcat_pkg::ENTRY_W-1:0] blk, logic [1:0] status);
      reply_t r;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report($sformatf("reply %0d: unexpected, block %0d status %0d",
                         replies_seen, $signed(blk), status));
        return;
      end
      r = pending_replies.pop_front();
      if (blk !== r.blk)
        report($sformatf("reply %0d: block %0d, want %0d",
                         replies_seen, $signed(blk), $signed(r.blk)));
      if (status !== r.status)
        report($sformatf("reply %0d: status %0d, want %0d",
                         replies_seen, status, r.status));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [12:0] cur_block
  logic [1:0]  in_tuser = '0;   // [1:0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [13:0] result_block
  logic [1:0]  out_tuser;       // [1:0] status

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int idle_cycles = 0;

  alloc_table_scoreboard sb = new();

  block_chain_allocation_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[bcat_pkg::ENTRY_W-1:0], out_tuser);
      if (in_tvalid && in_tready)
        sb.note_request(bcat_pkg::cmd_t'(in_tuser), in_tdata[bcat_pkg::CUR_W-1:0]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("block_chain_allocation_table: mismatch");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send_request(bcat_pkg::cmd_t cmd, logic [bcat_pkg::CUR_W-1:0] cur);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {3'b000, cur};
    in_tuser = cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function logic [bcat_pkg::CUR_W-1:0] pick_block();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      return bcat_pkg::CUR_W'($urandom_range(bcat_pkg::FIRST_DATA_BLOCK + 39,
                                             bcat_pkg::FIRST_DATA_BLOCK));
    if (r < 80)
      return bcat_pkg::CUR_W'($urandom_range(LAST_BLOCK, bcat_pkg::FIRST_DATA_BLOCK));
    if (r < 90)
      return bcat_pkg::CUR_W'($urandom_range(bcat_pkg::FIRST_DATA_BLOCK - 1, 0));
    return bcat_pkg::CUR_W'($urandom_range(8191, LAST_BLOCK + 1));
  endfunction

  task send_random();
    int             r;
    bcat_pkg::cmd_t cmd;
    r = $urandom_range(99);
    if (r < 25) cmd = bcat_pkg::CMD_ALLOC_FIRST;
    else if (r < 50) cmd = bcat_pkg::CMD_ALLOC_AFTER;
    else if (r < 70) cmd = bcat_pkg::CMD_NEXT_LINK;
    else cmd = bcat_pkg::CMD_RELEASE;
    send_request(cmd, pick_block());
  endtask

  task run_phase(int idle_pct, int stall_pct, int count);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    repeat (count) send_random();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: free reads, chain building, self loop, overwrite, range checks
    send_request(bcat_pkg::CMD_NEXT_LINK, 13'd5);
    send_request(bcat_pkg::CMD_RELEASE, 13'd5);
    send_request(bcat_pkg::CMD_ALLOC_FIRST, 13'd0);
    send_request(bcat_pkg::CMD_ALLOC_FIRST, 13'd0);
    send_request(bcat_pkg::CMD_ALLOC_AFTER, 13'd5);
    send_request(bcat_pkg::CMD_NEXT_LINK, 13'd5);
    send_request(bcat_pkg::CMD_NEXT_LINK, 13'd7);
    send_request(bcat_pkg::CMD_ALLOC_AFTER, 13'd5);
    send_request(bcat_pkg::CMD_ALLOC_AFTER, 13'd9);
    send_request(bcat_pkg::CMD_NEXT_LINK, 13'd9);
    send_request(bcat_pkg::CMD_ALLOC_AFTER, bcat_pkg::CUR_W'(LAST_BLOCK));
    send_request(bcat_pkg::CMD_NEXT_LINK, bcat_pkg::CUR_W'(LAST_BLOCK));
    send_request(bcat_pkg::CMD_RELEASE, bcat_pkg::CUR_W'(LAST_BLOCK));
    send_request(bcat_pkg::CMD_NEXT_LINK, bcat_pkg::CUR_W'(LAST_BLOCK));
    send_request(bcat_pkg::CMD_ALLOC_AFTER, 13'd4);
    send_request(bcat_pkg::CMD_NEXT_LINK, 13'd0);
    send_request(bcat_pkg::CMD_RELEASE, bcat_pkg::CUR_W'(LAST_BLOCK + 1));
    send_request(bcat_pkg::CMD_NEXT_LINK, 13'h1fff);
    send_request(bcat_pkg::CMD_ALLOC_AFTER, bcat_pkg::CUR_W'(LAST_BLOCK + 1));
    send_request(bcat_pkg::CMD_RELEASE, 13'd4);
    send_request(bcat_pkg::CMD_ALLOC_FIRST, 13'h1fff);
    send_request(bcat_pkg::CMD_RELEASE, 13'd6);
    send_request(bcat_pkg::CMD_ALLOC_FIRST, 13'd0);

    run_phase(0, 0, 29);
    run_phase(75, 0, 29);
    run_phase(0, 75, 29);
    run_phase(21, 21, 29);
    in_tvalid = 1'b0;

    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_replies.size() != 0)
      sb.report($sformatf("%0d replies missing", sb.pending_replies.size()));
    if (sb.errors == 0) begin
      $display("block_chain_allocation_table: match");
    end else begin
      $display("block_chain_allocation_table: mismatch");
    end
    $finish;
  end

endmodule
